/* hw/rtl/mtnm_pkg.sv */
// ----------------------------------------------------------------------------
// mtnm_pkg
// Shared types, codes and constants of the multichannel tone and noise mixer.
// ----------------------------------------------------------------------------
package mtnm_pkg;

  localparam int SR_W   = 20;          // sample rate and half period width
  localparam int FREQ_W = 16;
  localparam int DVS_W  = FREQ_W + 1;  // divisor is twice the frequency
  localparam int AMP_W  = 7;
  localparam int NOISE_W = 8;
  localparam int LFSR_W = 16;
  localparam int SMP_W  = 8;

  localparam logic [SR_W-1:0]    SAMPLE_RATE_RST = 20'd22050;
  localparam logic [NOISE_W-1:0] NOISE_RST       = 8'h80;
  localparam logic [LFSR_W-1:0]  LFSR_SEED       = 16'hACE1;
  localparam logic [LFSR_W-1:0]  LFSR_TAPS       = 16'hB400;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_MUTE   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_SCALE
  } state_t;

  typedef struct packed {
    logic [SR_W-1:0]    half_period;
    logic [SR_W-1:0]    countdown;
    logic               phase;
    logic               is_noise;
    logic [AMP_W-1:0]   amplitude;
    logic [NOISE_W-1:0] noise_hold;
  } chan_t;

  // galois lfsr, one shift to the right
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
    logic [LFSR_W-1:0] sh;
    sh = cur >> 1;
    if (cur[0]) begin
      sh = sh ^ LFSR_TAPS;
    end
    return sh;
  endfunction

endpackage

/* hw/rtl/multichannel_tone_noise_mixer.sv */
// ----------------------------------------------------------------------------
// multichannel_tone_noise_mixer
// Square wave and noise tone generator with a per-tick mixer and clipper.
// ----------------------------------------------------------------------------
// One item is handled at a time and in_stall is high while it is in work.
// A tick walks the channels one per cycle through a single update and
// accumulate path, then scales and clips in the scale step, which waits
// while the output beat is still stalled. A channel update with a nonzero
// frequency runs the serial divider for the half period, 20 steps. A mute,
// an update with frequency 0 or out of range, and an unused request type
// are handled in the idle state without raising in_stall.
// sample_rate may be written only while the block is idle.
module multichannel_tone_noise_mixer #(
  parameter int CHANNELS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mtnm_pkg::SR_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      req_type,
  input  logic [1:0]                      channel,
  input  logic [mtnm_pkg::FREQ_W-1:0]     frequency,
  input  logic                            sound_type,
  input  logic [mtnm_pkg::AMP_W-1:0]      volume,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [mtnm_pkg::SMP_W-1:0] sample
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int ACC_W = $clog2(CHANNELS * 128 + 1) + 1;
  localparam int SC_W  = ACC_W + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam logic signed [SC_W-1:0] CLIP_HI = SC_W'(127);
  localparam logic signed [SC_W-1:0] CLIP_LO = -CLIP_HI;
  localparam logic signed [SC_W-1:0] RND_NEG = SC_W'(3);

  mtnm_pkg::state_t state, state_next;

  logic [mtnm_pkg::SR_W-1:0]    sample_rate;
  logic [IDX_W-1:0]             idx_r;
  logic                         type_r;
  logic [mtnm_pkg::AMP_W-1:0]   vol_r;
  logic signed [ACC_W-1:0]      acc;
  logic [CNT_W-1:0]             act_cnt;
  logic [CNT_W-1:0]             prev_act;
  logic [mtnm_pkg::LFSR_W-1:0]  lfsr;

  logic                         accept;
  logic                         ch_ok;
  logic                         out_free;
  logic [IDX_W-1:0]             idx;
  mtnm_pkg::chan_t              rd, wr;
  logic                         bank_we, bank_clr;
  logic                         div_start, div_done;
  logic [mtnm_pkg::SR_W-1:0]    quotient;

  logic                         amp_on, wrap, draw;
  logic [mtnm_pkg::LFSR_W-1:0]  lfsr_adv;
  mtnm_pkg::chan_t              scan_ent;
  logic signed [ACC_W-1:0]      lvl;
  logic signed [SC_W-1:0]       acc_ext, t3, scaled;
  logic signed [mtnm_pkg::SMP_W-1:0] clipped;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != mtnm_pkg::S_IDLE);
  assign ch_ok    = (32'(channel) < CHANNELS);
  assign out_free = !out_valid || !out_stall;
  assign idx      = (state == mtnm_pkg::S_IDLE) ? IDX_W'(channel) : idx_r;

  mtnm_bank #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_bank (
    .clk (clk),
    .rst (rst),
    .idx (idx),
    .we  (bank_we),
    .wr  (wr),
    .clr (bank_clr),
    .rd  (rd)
  );

  mtnm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sample_rate),
    .divisor  ({frequency, 1'b0}),
    .done     (div_done),
    .quotient (quotient)
  );

  // one channel of a tick
  assign amp_on   = (rd.amplitude != '0);
  assign wrap     = (rd.countdown == '0);
  assign draw     = amp_on && wrap && rd.is_noise;
  assign lfsr_adv = mtnm_pkg::lfsr_step(lfsr);

  always_comb begin
    scan_ent = rd;
    if (wrap) begin
      scan_ent.countdown = rd.half_period;
      scan_ent.phase     = ~rd.phase;
      if (rd.is_noise) begin
        scan_ent.noise_hold = lfsr_adv[mtnm_pkg::NOISE_W-1:0];
      end
    end else begin
      scan_ent.countdown = rd.countdown - 1'b1;
    end
  end

  always_comb begin
    if (scan_ent.is_noise) begin
      // held byte minus 128 is the byte with its top bit flipped
      lvl = ACC_W'($signed({~scan_ent.noise_hold[7], scan_ent.noise_hold[6:0]}));
    end else if (scan_ent.phase) begin
      lvl = ACC_W'({1'b0, scan_ent.amplitude});
    end else begin
      lvl = -ACC_W'({1'b0, scan_ent.amplitude});
    end
  end

  // 3/4 scaling when more than one channel was active on the previous tick, truncated toward zero, then clip
  assign acc_ext = SC_W'(acc);
  assign t3      = acc_ext + (acc_ext <<< 1);

  always_comb begin
    if (prev_act > CNT_W'(1)) begin
      scaled = (t3 < 0) ? ((t3 + RND_NEG) >>> 2) : (t3 >>> 2);
    end else begin
      scaled = acc_ext;
    end
    if (scaled > CLIP_HI) begin
      clipped = mtnm_pkg::SMP_W'(CLIP_HI);
    end else if (scaled < CLIP_LO) begin
      clipped = mtnm_pkg::SMP_W'(CLIP_LO);
    end else begin
      clipped = mtnm_pkg::SMP_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtnm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    bank_we    = 1'b0;
    bank_clr   = 1'b0;
    div_start  = 1'b0;
    wr         = rd;
    unique case (state)
      mtnm_pkg::S_IDLE: begin
        if (accept) begin
          case (mtnm_pkg::req_t'(req_type))
            mtnm_pkg::REQ_TICK: state_next = mtnm_pkg::S_SCAN;
            mtnm_pkg::REQ_UPDATE: begin
              if (ch_ok) begin
                if (frequency != '0) begin
                  div_start  = 1'b1;
                  state_next = mtnm_pkg::S_DIV;
                end else begin
                  wr.amplitude = '0;
                  bank_we      = 1'b1;
                end
              end
            end
            mtnm_pkg::REQ_MUTE: bank_clr = 1'b1;
            default: ;
          endcase
        end
      end
      mtnm_pkg::S_DIV: begin
        if (div_done) begin
          wr.half_period = quotient;
          wr.countdown   = '0;
          wr.is_noise    = type_r;
          wr.amplitude   = vol_r;
          bank_we        = 1'b1;
          state_next     = mtnm_pkg::S_IDLE;
        end
      end
      mtnm_pkg::S_SCAN: begin
        wr      = scan_ent;
        bank_we = amp_on;
        if (idx_r == LAST_IDX) begin
          state_next = mtnm_pkg::S_SCALE;
        end
      end
      mtnm_pkg::S_SCALE: begin
        if (out_free) begin
          state_next = mtnm_pkg::S_IDLE;
        end
      end
      default: state_next = mtnm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= mtnm_pkg::SAMPLE_RATE_RST;
      prev_act    <= '0;
      lfsr        <= mtnm_pkg::LFSR_SEED;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        sample_rate <= cfg_wdata;
      end
      if (out_valid && !out_stall && (state != mtnm_pkg::S_SCALE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        mtnm_pkg::S_IDLE: begin
          if (accept) begin
            idx_r   <= (req_type == mtnm_pkg::REQ_TICK) ? '0 : IDX_W'(channel);
            type_r  <= sound_type;
            vol_r   <= volume;
            acc     <= '0;
            act_cnt <= '0;
          end
        end
        mtnm_pkg::S_SCAN: begin
          if (amp_on) begin
            acc     <= acc + lvl;
            act_cnt <= act_cnt + 1'b1;
          end
          if (draw) begin
            lfsr <= lfsr_adv;
          end
          idx_r <= idx_r + 1'b1;
        end
        mtnm_pkg::S_SCALE: begin
          // the beat in the register leaves or is overwritten here
          if (out_free) begin
            out_valid <= 1'b1;
            sample    <= clipped;
            prev_act  <= act_cnt;
          end
        end
        default: ;
      endcase
    end
  end

  // a result beat only ever comes out of the scale step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == mtnm_pkg::S_SCALE))
    else $error("output beat raised outside the scale step");

  // the clipper never lets -128 through
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample != -8'sd128))
    else $error("sample outside -127..127");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == mtnm_pkg::S_DIV))
    else $error("divider result with no update in work");

  // a nonzero galois lfsr can never reach zero
  assert property (@(posedge clk) disable iff (rst)
    lfsr != '0)
    else $error("noise lfsr locked at zero");

  // the scan index stays within the channel count
  assert property (@(posedge clk) disable iff (rst)
    (state == mtnm_pkg::S_SCAN) |-> (32'(idx_r) < CHANNELS))
    else $error("channel scan ran past the last channel");

endmodule

/* hw/rtl/mtnm_div.sv */
// ----------------------------------------------------------------------------
// mtnm_div
// Restoring divider, one quotient bit per cycle: sample rate over twice the
// tone frequency.
// ----------------------------------------------------------------------------
module mtnm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mtnm_pkg::SR_W-1:0]   dividend,
  input  logic [mtnm_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [mtnm_pkg::SR_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(mtnm_pkg::SR_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(mtnm_pkg::SR_W - 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [mtnm_pkg::SR_W-1:0]   quo;
  logic [mtnm_pkg::DVS_W-1:0]  rem;
  logic [mtnm_pkg::DVS_W-1:0]  dvs;

  logic [mtnm_pkg::DVS_W:0]    rem_sh;
  logic                        ge;
  logic [mtnm_pkg::DVS_W-1:0]  rem_next;

  assign rem_sh   = {rem, quo[mtnm_pkg::SR_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_next = ge ? mtnm_pkg::DVS_W'(rem_sh - {1'b0, dvs})
                       : rem_sh[mtnm_pkg::DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo <= {quo[mtnm_pkg::SR_W-2:0], ge};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* hw/rtl/mtnm_bank.sv */
// ----------------------------------------------------------------------------
// mtnm_bank
// Per-channel state registers with one shared read/write index and a
// mute that clears every channel at once, all but the held noise values.
// ----------------------------------------------------------------------------
module mtnm_bank #(
  parameter int CHANNELS = 4,
  parameter int IDX_W    = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IDX_W-1:0]     idx,
  input  logic                 we,
  input  mtnm_pkg::chan_t      wr,
  input  logic                 clr,
  output mtnm_pkg::chan_t      rd
);

  mtnm_pkg::chan_t ent [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ent[i].half_period <= '0;
        ent[i].countdown   <= '0;
        ent[i].phase       <= 1'b0;
        ent[i].is_noise    <= 1'b0;
        ent[i].amplitude   <= '0;
        ent[i].noise_hold  <= mtnm_pkg::NOISE_RST;
      end
    end else if (clr) begin
      // held noise values survive a mute
      for (int i = 0; i < CHANNELS; i++) begin
        ent[i].half_period <= '0;
        ent[i].countdown   <= '0;
        ent[i].phase       <= 1'b0;
        ent[i].is_noise    <= 1'b0;
        ent[i].amplitude   <= '0;
      end
    end else if (we) begin
      ent[idx] <= wr;
    end
  end

  assign rd = ent[idx];

endmodule
